// ===== sv/srpr_pkg.sv =====
// Shared types, constants and CRC/scramble helper functions for the
// scrambled radio payload receiver. No dependencies.
`default_nettype none

package srpr_pkg;

  localparam int unsigned PAYLOAD_BYTES_DEF = 15;
  localparam int unsigned POS_W = 5;
  localparam int unsigned ADDR_W = 40;
  localparam int unsigned CRC_W = 16;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_RX_ADDRESS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CRC_CHECK_ENABLE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CRC_FINAL_XOR = 2'd2;

  localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;
  localparam logic [CRC_W-1:0] CRC_SEED_BASE = 16'hb5d2;
  localparam logic [CRC_W-1:0] FINAL_XOR_RESET = 16'h9BA7;
  localparam logic [CRC_W-1:0] COUNT_MAX = 16'hFFFF;

  localparam int unsigned SCRAMBLE_LEN = 24;
  localparam logic [7:0] SCRAMBLE [SCRAMBLE_LEN] = '{
    8'he3, 8'hb1, 8'h4b, 8'hea, 8'h85, 8'hbc, 8'he5, 8'h66,
    8'h0d, 8'hae, 8'h8c, 8'h88, 8'h12, 8'h69, 8'hee, 8'h1f,
    8'hc7, 8'h62, 8'h97, 8'hd5, 8'h0b, 8'h79, 8'hca, 8'hcc
  };

  typedef struct packed {
    logic [7:0] raw_byte;
    logic       first_byte;
  } in_t;

  typedef struct packed {
    logic [7:0]       data_byte;
    logic             data_valid;
    logic             packet_done;
    logic             crc_ok;
    logic [CRC_W-1:0] error_count;
  } out_t;

  typedef struct packed {
    logic [POS_W-1:0] byte_position;
    logic [CRC_W-1:0] running_crc;
    logic [7:0]       received_crc_high;
    logic [CRC_W-1:0] failure_count;
  } state_t;

  // One byte of CRC-16, MSB first, no reflection.
  function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                input logic [7:0] b);
    logic [CRC_W-1:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[CRC_W-1] ? ({c[CRC_W-2:0], 1'b0} ^ CRC_POLY) : {c[CRC_W-2:0], 1'b0};
    end
    return c;
  endfunction

  function automatic logic [7:0] reverse8(input logic [7:0] v);
    logic [7:0] r;
    for (int k = 0; k < 8; k++) begin
      r[7-k] = v[k];
    end
    return r;
  endfunction

  function automatic logic [7:0] scramble_at(input logic [POS_W-1:0] idx);
    logic [7:0] s;
    s = 8'h00;
    if (idx < POS_W'(SCRAMBLE_LEN)) begin
      s = SCRAMBLE[idx];
    end
    return s;
  endfunction

  // Address seed, address bytes taken last byte first. Only evaluated on
  // constants at elaboration time.
  function automatic logic [CRC_W-1:0] address_seed(input logic [ADDR_W-1:0] addr);
    logic [CRC_W-1:0] c;
    logic [7:0] ab;
    c = CRC_SEED_BASE;
    for (int j = 0; j < 5; j++) begin
      ab = 8'(addr >> (8 * (4 - j)));
      c = crc_byte(c, ab ^ SCRAMBLE[j]);
    end
    return c;
  endfunction

  localparam logic [CRC_W-1:0] SEED_RESET = address_seed('0);

endpackage

`default_nettype wire

// ===== sv/srpr_step.sv =====
// Per-byte datapath of the receiver: position tracking, CRC update,
// descramble and CRC check. Depends on srpr_pkg.
`default_nettype none

module srpr_step #(
  parameter int unsigned PAYLOAD_BYTES = srpr_pkg::PAYLOAD_BYTES_DEF
) (
  input  var srpr_pkg::in_t                  item,
  input  var srpr_pkg::state_t               st,
  input  wire [srpr_pkg::CRC_W-1:0]          seed,
  input  wire                                check_en,
  input  wire [srpr_pkg::CRC_W-1:0]          final_xor,
  output srpr_pkg::state_t                   st_nxt,
  output srpr_pkg::out_t                     res
);

  localparam int unsigned POS_W = srpr_pkg::POS_W;
  localparam logic [POS_W-1:0] POS_PB = POS_W'(PAYLOAD_BYTES);
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(PAYLOAD_BYTES - 1);
  localparam logic [POS_W-1:0] POS_CRC_LO = POS_W'(PAYLOAD_BYTES + 1);
  localparam logic [POS_W-1:0] POS_IDLE = POS_W'(PAYLOAD_BYTES + 2);
  localparam logic [POS_W-1:0] SCR_OFFSET = POS_W'(5);

  logic [POS_W-1:0]          pos;
  logic [srpr_pkg::CRC_W-1:0] crc;
  logic [srpr_pkg::CRC_W-1:0] rx_crc;

  always_comb begin
    pos = item.first_byte ? '0 : st.byte_position;
    crc = item.first_byte ? seed : st.running_crc;
    rx_crc = {st.received_crc_high, item.raw_byte};
    st_nxt = st;
    st_nxt.byte_position = pos;
    st_nxt.running_crc = crc;
    res = '0;

    if (pos < POS_PB) begin
      st_nxt.running_crc = srpr_pkg::crc_byte(crc, item.raw_byte);
      res.data_byte = srpr_pkg::reverse8(item.raw_byte ^
                                         srpr_pkg::scramble_at(pos + SCR_OFFSET));
      res.data_valid = 1'b1;
      if (!check_en && pos == POS_LAST) begin
        // Without CRC bytes the packet ends on its last payload byte.
        res.packet_done = 1'b1;
        res.crc_ok = 1'b1;
        st_nxt.byte_position = POS_IDLE;
      end else begin
        st_nxt.byte_position = pos + POS_W'(1);
      end
    end else if (check_en && pos == POS_PB) begin
      st_nxt.received_crc_high = item.raw_byte;
      st_nxt.byte_position = pos + POS_W'(1);
    end else if (check_en && pos == POS_CRC_LO) begin
      res.packet_done = 1'b1;
      if ((crc ^ rx_crc) == final_xor) begin
        res.crc_ok = 1'b1;
      end else if (st.failure_count != srpr_pkg::COUNT_MAX) begin
        st_nxt.failure_count = st.failure_count + srpr_pkg::CRC_W'(1);
      end
      st_nxt.byte_position = POS_IDLE;
    end

    res.error_count = st_nxt.failure_count;
  end

endmodule

`default_nettype wire

// ===== sv/scrambled_radio_payload_receiver_unit.sv =====
// A request accepted at an edge is registered in the result register, or in
// the skid entry while out_stall holds it, before it shows on out_payload.
// One byte per cycle while in_stall is low; the combinational CRC byte update feeds the next byte's CRC.
// A two-entry output buffer (result register plus skid) keeps in_stall registered.
// Reset (synchronous, rst_n low) empties the buffer, clears position and
// counters, and restores the register defaults and the seed of address zero.
`default_nettype none

module scrambled_radio_payload_receiver_unit #(
  parameter int unsigned PAYLOAD_BYTES = srpr_pkg::PAYLOAD_BYTES_DEF
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 in_valid,
  output logic                                in_stall,
  input  var srpr_pkg::in_t                   in_payload,
  output logic                                out_valid,
  input  wire                                 out_stall,
  output srpr_pkg::out_t                      out_payload,
  input  wire                                 cfg_we,
  input  wire [srpr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire [srpr_pkg::ADDR_W-1:0]          cfg_wdata
);

  localparam int unsigned ADDR_W = srpr_pkg::ADDR_W;
  localparam int unsigned CRC_W = srpr_pkg::CRC_W;

  srpr_pkg::state_t state_r, state_nxt;
  srpr_pkg::out_t   res;
  srpr_pkg::out_t   out_r, skid_r;
  logic             out_valid_r, skid_valid_r;
  logic [CRC_W-1:0] seed_r, final_xor_r;
  logic             check_en_r;

  logic [CRC_W-1:0] seed_terms [ADDR_W];
  logic [CRC_W-1:0] seed_nxt;
  logic             in_take, out_take;

  // The seed is affine in the address, so it reduces to an XOR of one
  // constant column per address bit.
  for (genvar g = 0; g < ADDR_W; g++) begin : g_seed
    localparam logic [CRC_W-1:0] COL =
      srpr_pkg::address_seed(ADDR_W'(1) << g) ^ srpr_pkg::SEED_RESET;
    assign seed_terms[g] = cfg_wdata[g] ? COL : '0;
  end

  always_comb begin
    seed_nxt = srpr_pkg::SEED_RESET;
    for (int i = 0; i < ADDR_W; i++) begin
      seed_nxt = seed_nxt ^ seed_terms[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= srpr_pkg::SEED_RESET;
      check_en_r <= 1'b1;
      final_xor_r <= srpr_pkg::FINAL_XOR_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        srpr_pkg::REG_RX_ADDRESS:       seed_r <= seed_nxt;
        srpr_pkg::REG_CRC_CHECK_ENABLE: check_en_r <= cfg_wdata[0];
        srpr_pkg::REG_CRC_FINAL_XOR:    final_xor_r <= cfg_wdata[CRC_W-1:0];
        default: ;
      endcase
    end
  end

  srpr_step #(
    .PAYLOAD_BYTES(PAYLOAD_BYTES)
  ) u_step (
    .item      (in_payload),
    .st        (state_r),
    .seed      (seed_r),
    .check_en  (check_en_r),
    .final_xor (final_xor_r),
    .st_nxt    (state_nxt),
    .res       (res)
  );

  assign in_stall = skid_valid_r;
  assign in_take = in_valid && !skid_valid_r;
  assign out_take = out_valid_r && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.byte_position <= '0;
      state_r.running_crc <= srpr_pkg::SEED_RESET;
      state_r.received_crc_high <= '0;
      state_r.failure_count <= '0;
    end else if (in_take) begin
      state_r <= state_nxt;
    end
  end

  // Result register with a skid entry behind it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_take) begin
        out_r <= skid_r;
        skid_valid_r <= 1'b0;
      end
    end else if (in_take) begin
      if (!out_valid_r || out_take) begin
        out_r <= res;
        out_valid_r <= 1'b1;
      end else begin
        skid_r <= res;
        skid_valid_r <= 1'b1;
      end
    end else if (out_take) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_payload = out_r;

endmodule

`default_nettype wire

// ===== sv/srpr_checker.sv =====
// Port-level checks for the scrambled radio payload receiver, bound to
// the top level. Depends on srpr_pkg.
`default_nettype none

module srpr_checker (
  input wire                  clk,
  input wire                  rst_n,
  input wire                  out_valid,
  input wire                  out_stall,
  input var srpr_pkg::out_t   out_payload
);

  // Nothing is presented in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_payload))
    else $error("stalled result changed");

  a_ok_needs_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_payload.crc_ok |-> out_payload.packet_done)
    else $error("crc_ok without packet_done");

  a_idle_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_payload.data_valid |-> out_payload.data_byte == 8'h00)
    else $error("non-payload result carries data");

  // A packet that ends on a payload byte has no CRC to fail.
  a_payload_end_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_payload.data_valid && out_payload.packet_done
      |-> out_payload.crc_ok)
    else $error("packet ending on payload byte reported a CRC failure");

endmodule

bind scrambled_radio_payload_receiver_unit srpr_checker u_srpr_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .out_payload (out_payload)
);

`default_nettype wire

// ===== bench/tb_scrambled_radio_payload_receiver_unit.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the scrambled radio payload receiver: descramble, CRC-16
// check and failure counting, predicted per request. Depends on srpr_pkg and the unit.

module tb_scrambled_radio_payload_receiver_unit;
  import srpr_pkg::*;

  localparam logic [POS_W-1:0] PAY = POS_W'(PAYLOAD_BYTES_DEF);
  localparam logic [POS_W-1:0] POS_IDLE = PAY + 5'd2;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t in_payload = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_payload;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [ADDR_W-1:0] cfg_wdata = '0;

  // Register copies as the unit holds them.
  logic [ADDR_W-1:0] addr_set = '0;
  logic check_on = 1'b1;
  logic [CRC_W-1:0] final_xor_set = FINAL_XOR_RESET;

  // Packet tracking state of the prediction.
  logic [POS_W-1:0] pos_now;
  logic [CRC_W-1:0] crc_run;
  logic [7:0] crc_hi_held;
  logic [CRC_W-1:0] fail_total;

  in_t raw_byte_q[$];
  out_t rx_result_q[$];
  int fault_cnt = 0;
  int gap_left = 0;
  int stall_left = 0;
  int hold_left = 0;
  bit hold_ask = 1'b0;
  bit calm = 1'b0;

  scrambled_radio_payload_receiver_unit u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_payload(in_payload),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_payload(out_payload),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [CRC_W-1:0] crc16_upd(logic [CRC_W-1:0] c, logic [7:0] b);
    c = c ^ {b, 8'h00};
    repeat (8) c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    return c;
  endfunction

  function automatic logic [7:0] flip8(logic [7:0] v);
    logic [7:0] r;
    for (int k = 0; k < 8; k++) r[k] = v[7-k];
    return r;
  endfunction

  // The address goes in last byte first, each byte masked by the head of the table.
  function automatic logic [CRC_W-1:0] addr_crc_seed(logic [ADDR_W-1:0] a);
    logic [CRC_W-1:0] c;
    c = CRC_SEED_BASE;
    for (int j = 4; j >= 0; j--) c = crc16_upd(c, a[8*j +: 8] ^ SCRAMBLE[4-j]);
    return c;
  endfunction

  function automatic out_t descramble_byte(in_t req);
    out_t o;
    logic [CRC_W-1:0] got_crc;
    o = '0;
    if (req.first_byte) begin
      pos_now = '0;
      crc_run = addr_crc_seed(addr_set);
    end
    if (pos_now < PAY) begin
      crc_run = crc16_upd(crc_run, req.raw_byte);
      o.data_byte = flip8(req.raw_byte ^ SCRAMBLE[int'(pos_now) + 5]);
      o.data_valid = 1'b1;
      if (!check_on && pos_now == PAY - 5'd1) begin
        o.packet_done = 1'b1;
        o.crc_ok = 1'b1;
        pos_now = POS_IDLE;
      end else begin
        pos_now = pos_now + 5'd1;
      end
    end else if (check_on && pos_now == PAY) begin
      crc_hi_held = req.raw_byte;
      pos_now = pos_now + 5'd1;
    end else if (check_on && pos_now == PAY + 5'd1) begin
      got_crc = {crc_hi_held, req.raw_byte};
      o.packet_done = 1'b1;
      if ((crc_run ^ got_crc) == final_xor_set) begin
        o.crc_ok = 1'b1;
      end else if (fail_total != COUNT_MAX) begin
        fail_total = fail_total + 16'd1;
      end
      pos_now = POS_IDLE;
    end
    o.error_count = fail_total;
    return o;
  endfunction

  function automatic void push_raw(logic [7:0] b, logic f);
    in_t r;
    r.raw_byte = b;
    r.first_byte = f;
    raw_byte_q.push_back(r);
  endfunction

  // Queues one packet under the current register values. Full-length packets get
  // their CRC bytes when checking is on; a bad CRC is off by a nonzero pattern.
  function automatic int queue_packet(int n_pay, bit crc_good);
    logic [CRC_W-1:0] c;
    logic [7:0] b;
    c = addr_crc_seed(addr_set);
    for (int k = 0; k < n_pay; k++) begin
      case ($urandom_range(0, 7))
        0: b = 8'h00;
        1: b = 8'hff;
        default: b = 8'($urandom);
      endcase
      c = crc16_upd(c, b);
      push_raw(b, k == 0);
    end
    if (check_on && n_pay == int'(PAY)) begin
      c = c ^ final_xor_set;
      if (!crc_good) c = c ^ 16'($urandom_range(1, 65535));
      push_raw(c[15:8], 1'b0);
      push_raw(c[7:0], 1'b0);
      return n_pay + 2;
    end
    return n_pay;
  endfunction

  task automatic queue_random_traffic(input int n_items);
    int made;
    int pick;
    int n;
    made = 0;
    while (made < n_items) begin
      pick = $urandom_range(0, 9);
      if (pick <= 6) begin
        made += queue_packet(int'(PAY), $urandom_range(0, 2) != 0);
      end else if (pick == 7) begin
        // Cut short: the next packet start overrides it.
        made += queue_packet($urandom_range(1, int'(PAY) - 1), 1'b1);
      end else begin
        n = $urandom_range(1, 6);
        for (int k = 0; k < n; k++) push_raw(8'($urandom), $urandom_range(0, 3) == 0);
        made += n;
      end
    end
  endtask

  task automatic wait_idle();
    while (raw_byte_q.size() != 0 || in_valid || rx_result_q.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ADDR_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_RX_ADDRESS: addr_set = val;
      REG_CRC_CHECK_ENABLE: check_on = val[0];
      REG_CRC_FINAL_XOR: final_xor_set = val[CRC_W-1:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic check_field(input string fname, input logic [15:0] want_v,
                             input logic [15:0] got_v);
    if (got_v !== want_v) begin
      if (fault_cnt < 10) $display("mismatch in %s: expected %h, got %h", fname, want_v, got_v);
      fault_cnt++;
    end
  endtask

  // Request driver: takes the next byte from the queue, with random gaps.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left = 0;
      pos_now = '0;
      crc_run = addr_crc_seed('0);
      crc_hi_held = '0;
      fail_total = '0;
    end else begin
      if (in_valid && !in_stall) rx_result_q.push_back(descramble_byte(in_payload));
      if (!(in_valid && in_stall)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (!calm && $urandom_range(0, 11) == 0) begin
          gap_left = $urandom_range(0, 16);
          in_valid <= 1'b0;
        end else if (raw_byte_q.size() > 0) begin
          in_payload <= raw_byte_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result side stall: random bursts, plus one long hold-off on request.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (hold_ask) begin
      hold_ask = 1'b0;
      hold_left = 80;
      out_stall <= 1'b1;
    end else if (calm) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 15) == 0) begin
      stall_left = $urandom_range(0, 16);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (rx_result_q.size() == 0) begin
        if (fault_cnt < 10) $display("result with nothing expected: %p", out_payload);
        fault_cnt++;
      end else begin
        check_field("data_byte", rx_result_q[0].data_byte, out_payload.data_byte);
        check_field("data_valid", rx_result_q[0].data_valid, out_payload.data_valid);
        check_field("packet_done", rx_result_q[0].packet_done, out_payload.packet_done);
        check_field("crc_ok", rx_result_q[0].crc_ok, out_payload.crc_ok);
        check_field("error_count", rx_result_q[0].error_count, out_payload.error_count);
        void'(rx_result_q.pop_front());
      end
    end
  end

  initial begin
    logic [7:0] pay [PAYLOAD_BYTES_DEF];
    logic [CRC_W-1:0] c;
    logic [ADDR_W-1:0] addr_v;
    logic chk_v;
    logic [CRC_W-1:0] xor_v;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // A packet with no start flag after reset, seeded from the reset address.
    // The address changes mid-packet, which must not touch the seed, and the
    // check is switched off after the payload so one byte is dropped.
    pay[0] = 8'h00;
    pay[1] = 8'hff;
    for (int k = 2; k < int'(PAY); k++) pay[k] = 8'($urandom);
    c = addr_crc_seed(addr_set);
    for (int k = 0; k < int'(PAY); k++) c = crc16_upd(c, pay[k]);
    c = c ^ final_xor_set;
    push_raw(pay[0], 1'b0);
    push_raw(pay[1], 1'b0);
    wait_idle();
    write_reg(REG_RX_ADDRESS, '1);
    for (int k = 2; k < int'(PAY); k++) push_raw(pay[k], 1'b0);
    wait_idle();
    write_reg(REG_CRC_CHECK_ENABLE, 40'd0);
    push_raw(8'h5a, 1'b0);
    wait_idle();
    write_reg(REG_CRC_CHECK_ENABLE, 40'd1);
    push_raw(c[15:8], 1'b0);
    push_raw(c[7:0], 1'b0);
    // Past the end of the packet: ignored.
    push_raw(8'hff, 1'b0);
    wait_idle();

    for (int ph = 0; ph < 8; ph++) begin
      addr_v = {8'($urandom), $urandom};
      if (ph == 0) addr_v = '0;
      if (ph == 1) addr_v = '1;
      chk_v = (ph == 2 || ph == 4) ? 1'b0 : (ph >= 5 ? 1'($urandom_range(0, 1)) : 1'b1);
      xor_v = ph == 0 ? 16'h0000 : ph == 1 ? 16'hffff : ph == 3 ? FINAL_XOR_RESET
            : 16'($urandom);
      write_reg(REG_RX_ADDRESS, addr_v);
      write_reg(REG_CRC_CHECK_ENABLE, {39'd0, chk_v});
      write_reg(REG_CRC_FINAL_XOR, {24'd0, xor_v});
      if (ph == 3) hold_ask = 1'b1;
      queue_random_traffic(84);
      wait_idle();
    end

    // Last part, no idling: two failing packets back to back, then a good one.
    calm = 1'b1;
    write_reg(REG_CRC_CHECK_ENABLE, 40'd1);
    write_reg(REG_RX_ADDRESS, {8'($urandom), $urandom});
    write_reg(REG_CRC_FINAL_XOR, {24'd0, 16'($urandom)});
    for (int k = 0; k < 3; k++) void'(queue_packet(int'(PAY), k == 2));
    wait_idle();
    repeat (10) @(negedge clk);
    if (fault_cnt == 0) begin
      $display("scrambled_radio_payload_receiver_unit test passed");
    end else begin
      $display("scrambled_radio_payload_receiver_unit test failed");
    end
    $finish;
  end

  initial begin
    #10000000;
    $display("scrambled_radio_payload_receiver_unit test failed");
    $finish;
  end

endmodule
